// File: hw/rtl/spsi_pkg.sv
// ----------------------------------------------------------------------------
// spsi_pkg: shared types and constants of the stable priority table
// Operation and status codes, default sizes and the control word of a cell.
// ----------------------------------------------------------------------------
`default_nettype none

package spsi_pkg;

   localparam int MAX_ENTRIES_DEF  = 16;
   localparam int KEY_BITS_DEF     = 16;
   localparam int PAYLOAD_BITS_DEF = 32;
   localparam int COUNT_BITS_DEF   = 5;
   localparam int INDEX_BITS       = 4;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_READ   = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;
   localparam logic [1:0] STATUS_RANGE   = 2'd3;

   // per-cell control from the table controller
   typedef struct packed {
      logic write_en;   // accepted insert that will be stored
      logic occupied;   // cell lies below the fill count
      logic at_tail;    // cell is the first free slot
   } spsi_cell_ctl_type;

endpackage

`default_nettype wire

// File: hw/rtl/spsi_if.sv
// ----------------------------------------------------------------------------
// spsi_if: request and response channels of the stable priority table
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface spsi_req_if #(
   parameter int KEY_BITS     = spsi_pkg::KEY_BITS_DEF,
   parameter int PAYLOAD_BITS = spsi_pkg::PAYLOAD_BITS_DEF
);
   import spsi_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [1:0]               func;
   logic [KEY_BITS-1:0]      priority_req;
   logic [PAYLOAD_BITS-1:0]  payload;
   logic                     desc_ok;
   logic [INDEX_BITS-1:0]    index;

   modport source (
      output valid, func, priority_req, payload, desc_ok, index,
      input  ready
   );
   modport sink (
      input  valid, func, priority_req, payload, desc_ok, index,
      output ready
   );
endinterface

interface spsi_rsp_if #(
   parameter int KEY_BITS     = spsi_pkg::KEY_BITS_DEF,
   parameter int PAYLOAD_BITS = spsi_pkg::PAYLOAD_BITS_DEF,
   parameter int COUNT_BITS   = spsi_pkg::COUNT_BITS_DEF
);
   logic                     valid;
   logic                     ready;
   logic [1:0]               status;
   logic [KEY_BITS-1:0]      read_priority;
   logic [PAYLOAD_BITS-1:0]  read_payload;
   logic [COUNT_BITS-1:0]    entries_held;

   modport source (
      output valid, status, read_priority, read_payload, entries_held,
      input  ready
   );
   modport sink (
      input  valid, status, read_priority, read_payload, entries_held,
      output ready
   );
endinterface

`default_nettype wire

// File: hw/rtl/spsi_cell.sv
// ----------------------------------------------------------------------------
// spsi_cell: one slot of the sorted table
// Holds one key and payload; compares against the new key and either holds,
// loads the new entry or loads the entry shifted up from its lower neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module spsi_cell #(
   parameter int KEY_BITS     = spsi_pkg::KEY_BITS_DEF,
   parameter int PAYLOAD_BITS = spsi_pkg::PAYLOAD_BITS_DEF
) (
   input  wire                             clock,
   input  spsi_pkg::spsi_cell_ctl_type     ctl,
   input  wire [KEY_BITS-1:0]              new_key,
   input  wire [PAYLOAD_BITS-1:0]          new_payload,
   input  wire                             prev_take,
   input  wire [KEY_BITS-1:0]              prev_key,
   input  wire [PAYLOAD_BITS-1:0]          prev_payload,
   output logic                            take,
   output logic [KEY_BITS-1:0]             key,
   output logic [PAYLOAD_BITS-1:0]         payload
);
   import spsi_pkg::*;

   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [PAYLOAD_BITS-1:0] payload_ff, payload_in;

   // this slot or one below it receives the new entry
   assign take = ctl.at_tail || (ctl.occupied && (new_key < key_ff));

   always_comb begin
      key_in     = key_ff;
      payload_in = payload_ff;
      if (ctl.write_en) begin
         priority if (prev_take) begin
            key_in     = prev_key;
            payload_in = prev_payload;
         end else if (take) begin
            key_in     = new_key;
            payload_in = new_payload;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      payload_ff <= payload_in;
   end

   assign key     = key_ff;
   assign payload = payload_ff;

endmodule

`default_nettype wire

// File: hw/rtl/stable_priority_sorted_insert_top.sv
// ----------------------------------------------------------------------------
// stable_priority_sorted_insert_top: bounded table kept in priority order
// A row of compare-and-shift cells with a fill counter and a response register.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one operation word: insert (priority, payload, desc_ok),
//   read (index) or clear. rsp returns one word per request: status, the
//   entry read (zero unless a read succeeds) and the entry count afterwards.
//   Inserts land before the first stored entry of strictly higher priority,
//   so equal priorities keep arrival order; a refused insert (invalid
//   descriptor first, then full table) leaves the table as it was.
//   A response appears in the cycle after its request is taken. Every cell compares and
//   shifts in the same cycle, so one word is taken per cycle as long as the
//   response register drains.
//   req.ready is high while the response register is empty or being taken
//   this cycle; a stalled rsp holds its word and blocks new requests.
//   Synchronous reset empties the table and the response register; the
//   key and payload cells are not cleared, slots at or above the count are
//   never read.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_priority_sorted_insert_top #(
   parameter int MAX_ENTRIES  = spsi_pkg::MAX_ENTRIES_DEF,
   parameter int KEY_BITS     = spsi_pkg::KEY_BITS_DEF,
   parameter int PAYLOAD_BITS = spsi_pkg::PAYLOAD_BITS_DEF
) (
   input  wire          clock,
   input  wire          reset,
   spsi_req_if.sink     req,
   spsi_rsp_if.source   rsp
);
   import spsi_pkg::*;

   localparam int CW   = $clog2(MAX_ENTRIES + 1);
   localparam int XW   = INDEX_BITS + CW;
   localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ENTRIES);

   // fill counter and response register
   logic [CW-1:0]           fill_ff, fill_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              status_ff, status_in;
   logic [KEY_BITS-1:0]     rkey_ff, rkey_in;
   logic [PAYLOAD_BITS-1:0] rword_ff, rword_in;

   logic accept;
   logic do_insert;
   logic in_range;
   logic [XW-1:0] index_ext;

   spsi_cell_ctl_type       ctl  [MAX_ENTRIES];
   logic                    take [MAX_ENTRIES];
   logic [KEY_BITS-1:0]     ckey [MAX_ENTRIES];
   logic [PAYLOAD_BITS-1:0] cpay [MAX_ENTRIES];
   logic [KEY_BITS-1:0]     sel_key;
   logic [PAYLOAD_BITS-1:0] sel_pay;

   // take a new word whenever the response slot is free or draining
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   assign do_insert = accept && (req.func == FUNC_INSERT) && req.desc_ok
                      && (fill_ff != FULL_COUNT);

   assign index_ext = {{CW{1'b0}}, req.index};
   assign in_range  = index_ext < {{INDEX_BITS{1'b0}}, fill_ff};

   // per-cell control: occupancy below the count, tail slot at the count
   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         ctl[i].write_en = do_insert;
         ctl[i].occupied = CW'(i) < fill_ff;
         ctl[i].at_tail  = CW'(i) == fill_ff;
      end
   end

   // the cell row: each slot hands its entry to the one above on a shift
   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      if (g == 0) begin : g_head
         spsi_cell #(
            .KEY_BITS     (KEY_BITS),
            .PAYLOAD_BITS (PAYLOAD_BITS)
         ) u_cell (
            .clock        (clock),
            .ctl          (ctl[g]),
            .new_key      (req.priority_req),
            .new_payload  (req.payload),
            .prev_take    (1'b0),
            .prev_key     (req.priority_req),
            .prev_payload (req.payload),
            .take         (take[g]),
            .key          (ckey[g]),
            .payload      (cpay[g])
         );
      end else begin : g_body
         spsi_cell #(
            .KEY_BITS     (KEY_BITS),
            .PAYLOAD_BITS (PAYLOAD_BITS)
         ) u_cell (
            .clock        (clock),
            .ctl          (ctl[g]),
            .new_key      (req.priority_req),
            .new_payload  (req.payload),
            .prev_take    (take[g-1]),
            .prev_key     (ckey[g-1]),
            .prev_payload (cpay[g-1]),
            .take         (take[g]),
            .key          (ckey[g]),
            .payload      (cpay[g])
         );
      end
   end

   // read select over the row
   always_comb begin
      sel_key = '0;
      sel_pay = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (index_ext == XW'(i)) begin
            sel_key = ckey[i];
            sel_pay = cpay[i];
         end
      end
   end

   // next count and response word
   always_comb begin
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      rkey_in      = rkey_ff;
      rword_in     = rword_ff;
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         status_in    = STATUS_OK;
         rkey_in      = '0;
         rword_in     = '0;
         unique case (req.func)
            FUNC_INSERT: begin
               priority if (!req.desc_ok) begin
                  status_in = STATUS_INVALID;
               end else if (fill_ff == FULL_COUNT) begin
                  status_in = STATUS_FULL;
               end else begin
                  fill_in = fill_ff + CW'(1);
               end
            end
            FUNC_READ: begin
               if (in_range) begin
                  rkey_in  = sel_key;
                  rword_in = sel_pay;
               end else begin
                  status_in = STATUS_RANGE;
               end
            end
            FUNC_CLEAR: begin
               fill_in = '0;
            end
            default: begin
               // unused code: no change, status ok
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      rkey_ff   <= rkey_in;
      rword_ff  <= rword_in;
   end

   // count is stable while a response waits, since no word is taken then
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = status_ff;
   assign rsp.read_priority = rkey_ff;
   assign rsp.read_payload  = rword_ff;
   assign rsp.entries_held  = fill_ff;

endmodule

`default_nettype wire

// File: bench/stable_priority_sorted_insert_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_sorted_insert_top_tb: self-checking bench of the priority table
// Drives insert, read, clear and unused operation words through the request
// channel, tracks the table contents in a scoreboard and compares every reply
// field by field, with random idle bursts on both channels and forced back-pressure.
// ----------------------------------------------------------------------------

module stable_priority_sorted_insert_top_tb;
   import spsi_pkg::*;

   localparam int MAX_N   = MAX_ENTRIES_DEF;
   localparam int KEY_W   = KEY_BITS_DEF;
   localparam int PAY_W   = PAYLOAD_BITS_DEF;
   localparam int COUNT_W = COUNT_BITS_DEF;

   // opcode the block must treat as a no-op
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS = 1200;
   localparam int QUIET_TAIL   = 200;   // last words of the run go without idling
   localparam int LONG_HOLD    = 60;    // cycles the receiver stalls to back up the block
   localparam int HOLD_START   = 300;
   localparam int HOLD_WORDS   = 40;
   localparam int DRAIN_AT     = 700;
   localparam int SETTLE       = 4;
   localparam longint LIMIT_NS = 3_000_000;

   typedef struct packed {
      logic [1:0]            func;
      logic [KEY_W-1:0]      priority_req;
      logic [PAY_W-1:0]      payload;
      logic                  desc_ok;
      logic [INDEX_BITS-1:0] index;
   } request_word_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [KEY_W-1:0]   read_priority;
      logic [PAY_W-1:0]   read_payload;
      logic [COUNT_W-1:0] entries_held;
   } reply_word_type;

   // Scoreboard: keeps its own sorted copy of the table and the replies it owes.
   class priority_table_sb_type;
      logic [KEY_W-1:0] keys [MAX_N];
      logic [PAY_W-1:0] words [MAX_N];
      int               fill;
      reply_word_type   expected_replies [$];
      int unsigned      fails;
      int unsigned      replies_seen;

      function new();
         fill = 0;
         fails = 0;
         replies_seen = 0;
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction

      task report(input string line);
         $display("reply %0d: %s", replies_seen, line);
         fails++;
      endtask

      // work out the reply of one accepted word and update the table
      function void note_request(input request_word_type w);
         reply_word_type r;
         int             k;
         r = '0;
         case (w.func)
            FUNC_INSERT: begin
               if (!w.desc_ok) begin
                  r.status = STATUS_INVALID;
               end else if (fill == MAX_N) begin
                  r.status = STATUS_FULL;
               end else begin
                  // shift strictly greater keys up, equal keys stay below
                  k = fill;
                  while (k > 0 && keys[k-1] > w.priority_req) begin
                     keys[k]  = keys[k-1];
                     words[k] = words[k-1];
                     k--;
                  end
                  keys[k]  = w.priority_req;
                  words[k] = w.payload;
                  fill++;
               end
            end
            FUNC_READ: begin
               if (int'(w.index) < fill) begin
                  r.read_priority = keys[w.index];
                  r.read_payload  = words[w.index];
               end else begin
                  r.status = STATUS_RANGE;
               end
            end
            FUNC_CLEAR: fill = 0;
            default: ;
         endcase
         r.entries_held = COUNT_W'(fill);
         expected_replies.push_back(r);
      endfunction

      task check_reply(input reply_word_type got);
         reply_word_type want;
         replies_seen++;
         if (expected_replies.size() == 0) begin
            report("reply arrived with nothing pending");
         end else begin
            want = expected_replies.pop_front();
            if (got.status !== want.status)
               report($sformatf("status got %0h expected %0h", got.status, want.status));
            if (got.read_priority !== want.read_priority)
               report($sformatf("read_priority got %0h expected %0h",
                                got.read_priority, want.read_priority));
            if (got.read_payload !== want.read_payload)
               report($sformatf("read_payload got %0h expected %0h",
                                got.read_payload, want.read_payload));
            if (got.entries_held !== want.entries_held)
               report($sformatf("entries_held got %0d expected %0d",
                                got.entries_held, want.entries_held));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   spsi_req_if req_if ();
   spsi_rsp_if rsp_if ();

   stable_priority_sorted_insert_top u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   priority_table_sb_type sb = new();

   // flags shared between the sender and the receiver, and the receiver's hold count
   bit gaps_on       = 1'b1;   // random idle bursts allowed
   bit long_hold_req = 1'b0;   // sender asks the receiver for a long stall
   int hold_left     = 0;

   always #5 clock = ~clock;

   function automatic request_word_type op_word(input logic [1:0] func,
                                                input logic [KEY_W-1:0] prio,
                                                input logic [PAY_W-1:0] payload,
                                                input logic ok,
                                                input logic [INDEX_BITS-1:0] index);
      request_word_type w;
      w.func         = func;
      w.priority_req = prio;
      w.payload      = payload;
      w.desc_ok      = ok;
      w.index        = index;
      return w;
   endfunction

   // Mostly inserts and reads, clears often enough that the table
   // runs through empty, partly filled and full many times.
   function automatic request_word_type random_word();
      request_word_type w;
      int unsigned      pick;
      int unsigned      kind;
      pick = $urandom_range(0, 99);
      kind = $urandom_range(0, 99);
      if (pick < 55)      w.func = FUNC_INSERT;
      else if (pick < 93) w.func = FUNC_READ;
      else if (pick < 97) w.func = FUNC_CLEAR;
      else                w.func = FUNC_UNUSED;
      // narrow keys make equal priorities common, so order stability is exercised
      if (kind < 45)      w.priority_req = KEY_W'($urandom_range(0, 7));
      else if (kind < 55) w.priority_req = '0;
      else if (kind < 65) w.priority_req = '1;
      else                w.priority_req = KEY_W'($urandom);
      w.payload = PAY_W'($urandom);
      w.desc_ok = ($urandom_range(0, 9) != 0);
      w.index   = INDEX_BITS'($urandom_range(0, MAX_N - 1));
      return w;
   endfunction

   // Present one word and hold it until the block takes it.
   // Call right after a rising edge.
   task automatic send_item(input request_word_type w);
      req_if.valid        <= 1'b1;
      req_if.func         <= w.func;
      req_if.priority_req <= w.priority_req;
      req_if.payload      <= w.payload;
      req_if.desc_ok      <= w.desc_ok;
      req_if.index        <= w.index;
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(w);
   endtask

   task automatic pause_sender(input int cycles);
      req_if.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Receiver: check every reply taken, then pick the next ready value.
   // Long stalls are counted here, random bursts only while gaps are on.
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready)
            sb.check_reply({rsp_if.status, rsp_if.read_priority,
                            rsp_if.read_payload, rsp_if.entries_held});
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD - 1;
            rsp_if.ready <= 1'b0;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(0, 6);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Sender: reset, directed corners, then the random run.
   initial begin
      bit in_burst;
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.func         <= FUNC_INSERT;
      req_if.priority_req <= '0;
      req_if.payload      <= '0;
      req_if.desc_ok      <= 1'b0;
      req_if.index        <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // read of an empty table is out of range
      send_item(op_word(FUNC_READ, '0, '0, 1'b1, '0));
      // extreme keys and payloads; the refused insert must not land
      send_item(op_word(FUNC_INSERT, '0, '1, 1'b1, '0));
      send_item(op_word(FUNC_INSERT, '1, 32'h1234_5678, 1'b0, '0));
      send_item(op_word(FUNC_INSERT, '1, '0, 1'b1, '0));
      // equal key goes after the earlier one
      send_item(op_word(FUNC_INSERT, '0, 32'hA5A5_5A5A, 1'b1, '0));
      for (int k = 0; k < 3; k++)
         send_item(op_word(FUNC_READ, '1, '1, 1'b0, INDEX_BITS'(k)));
      // unused opcode with every other field set
      send_item(op_word(FUNC_UNUSED, '1, '1, 1'b1, '1));
      send_item(op_word(FUNC_READ, '0, '0, 1'b1, '1));
      // fill to the top with interleaved near-equal keys
      for (int k = 0; k < MAX_N - 3; k++)
         send_item(op_word(FUNC_INSERT, (k % 2) ? 16'h7FFF : 16'h8000,
                           PAY_W'(k), 1'b1, '0));
      // full table: full status, and the invalid flag wins over full
      send_item(op_word(FUNC_INSERT, 16'h0001, 32'hDEAD_BEEF, 1'b1, '0));
      send_item(op_word(FUNC_INSERT, 16'h0001, 32'hDEAD_BEEF, 1'b0, '0));
      send_item(op_word(FUNC_READ, '0, '0, 1'b1, '1));
      send_item(op_word(FUNC_CLEAR, '1, '1, 1'b1, '1));
      send_item(op_word(FUNC_READ, '0, '0, 1'b1, '0));

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         in_burst = (i >= HOLD_START) && (i < HOLD_START + HOLD_WORDS);
         gaps_on  = (i < RANDOM_ITEMS - QUIET_TAIL) && ((i / 100) % 3 != 2);
         // stall the receiver while words keep coming, so the input backs up
         if (i == HOLD_START)
            long_hold_req = 1'b1;
         // let everything drain before going on
         if (i == DRAIN_AT)
            wait_drained();
         if (gaps_on && !in_burst && $urandom_range(0, 3) == 0)
            pause_sender($urandom_range(1, 7));
         send_item(random_word());
      end

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (sb.fails == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   initial begin
      #(LIMIT_NS);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
